>>> rtl/pnd_pkg.sv
package pnd_pkg;

	// Escape marker and radix of the two hex digits that follow it
	localparam logic [7:0] ESC_MARK = 8'h23;
	localparam int unsigned HEX_RADIX = 16;

	// Default depth of the result queue (power of two, at least 2)
	localparam int unsigned OUTQ_DEPTH = 4;

	// One decoded result
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} res_t;

	// Results produced by one decoded byte, up to two
	typedef struct packed {
		logic [1:0] cnt;
		res_t       r0;
		res_t       r1;
	} push_t;

	// Hex digit value; any non-hex byte counts as zero
	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = 4'(c - 8'h61 + 8'd10);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = 4'(c - 8'h41 + 8'd10);
		end
		return v;
	endfunction

endpackage

>>> rtl/pdf_name_escape_decoder.sv
// Removes '#' hex escapes from a name streamed one byte per transfer, tlast on
// the final byte. A '#' followed by two more bytes of the same name becomes one
// byte (high digit, low digit; case-insensitive, a non-hex byte counts as 0).
// If the name ends before two bytes follow a '#', the held bytes come out
// literally. One input byte is accepted every cycle while the result queue has
// room. A completed byte passes the input register, then the result queue, and
// is offered at the output from the queue. The rate is set by the single decode
// stage and the one-result-per-cycle read port of the queue (OUTQ_DEPTH
// entries), which absorbs the case of a name ending one byte after '#' that
// yields two bytes.
module pdf_name_escape_decoder #(
	parameter int unsigned OUTQ_DEPTH = pnd_pkg::OUTQ_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,    // in_byte[7:0]
	input  logic       s_tlast,    // in_last
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,    // out_byte[7:0]
	output logic       m_tlast     // out_last
);

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_MARK  = 2'd1,
		PH_DIGIT = 2'd2
	} phase_t;

	phase_t         phase_q, phase_d;
	logic [7:0]     held_q, held_d;
	logic           valid_s1;
	logic [7:0]     byte_s1;
	logic           last_s1;
	logic           room;
	logic           adv;
	pnd_pkg::push_t push;
	pnd_pkg::push_t dec;

	assign adv      = valid_s1 && room;
	assign s_tready = !valid_s1 || room;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// Escape decode of the registered byte
	always_comb begin
		phase_d    = PH_IDLE;
		held_d     = held_q;
		dec.cnt    = 2'd1;
		dec.r0     = '{data: byte_s1, last: last_s1};
		dec.r1     = '{data: byte_s1, last: 1'b1};
		unique case (phase_q)
			PH_MARK: begin
				if (last_s1) begin
					dec.cnt = 2'd2;
					dec.r0  = '{data: pnd_pkg::ESC_MARK, last: 1'b0};
				end else begin
					dec.cnt = 2'd0;
					held_d  = byte_s1;
					phase_d = PH_DIGIT;
				end
			end
			PH_DIGIT: begin
				dec.r0.data = 8'(32'(pnd_pkg::hex_value(held_q)) * pnd_pkg::HEX_RADIX
					+ 32'(pnd_pkg::hex_value(byte_s1)));
			end
			default: begin
				if (byte_s1 == pnd_pkg::ESC_MARK && !last_s1) begin
					dec.cnt = 2'd0;
					phase_d = PH_MARK;
				end
			end
		endcase
	end

	always_comb begin
		push     = dec;
		push.cnt = adv ? dec.cnt : 2'd0;
	end

	// Escape state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= 8'd0;
		end else if (adv) begin
			phase_q <= phase_d;
			held_q  <= held_d;
		end
	end

	pnd_outq #(
		.DEPTH(OUTQ_DEPTH)
	) u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	a_two_only_on_short_escape: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt == 2'd2 |-> phase_q == PH_MARK && last_s1)
		else $error("two results outside a cut-short escape");

	a_digit_after_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && phase_q == PH_MARK && !last_s1) |=> phase_q == PH_DIGIT)
		else $error("first digit not held after marker");

	a_last_clears_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_s1) |=> phase_q == PH_IDLE)
		else $error("escape pending across end of name");

endmodule

>>> rtl/pnd_outq.sv
// Small result queue: takes up to two results per cycle, gives one per cycle while m_tready is high
module pnd_outq #(
	parameter int unsigned DEPTH = pnd_pkg::OUTQ_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  pnd_pkg::push_t push,
	output logic           room,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [7:0]     m_tdata,   // out_byte[7:0]
	output logic           m_tlast    // out_last
);

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	pnd_pkg::res_t mem_q [DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [CW-1:0] count_q;
	logic          pop;
	logic [PW-1:0] wptr_p1;

	assign pop      = m_tvalid && m_tready;
	assign wptr_p1  = wptr_q + PW'(1);
	assign room     = count_q <= CW'(DEPTH - 2);
	assign m_tvalid = count_q != '0;
	assign m_tdata  = mem_q[rptr_q].data;
	assign m_tlast  = mem_q[rptr_q].last;

	// Storage writes
	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wptr_q] <= push.r0;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wptr_p1] <= push.r1;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= wptr_q + PW'(push.cnt);
			if (pop) begin
				rptr_q <= rptr_q + PW'(1);
			end
			count_q <= count_q + CW'(push.cnt) - CW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt != 2'd0 |-> (CW + 1)'(count_q) + (CW + 1)'(push.cnt) <= (CW + 1)'(DEPTH))
		else $error("result queue overflow");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt == 2'd0 && !pop) |=> $stable(count_q))
		else $error("queue count moved without a transfer");

endmodule

>>> sim/pdf_name_escape_decoder_tb.sv
`timescale 1ns / 100ps

module pdf_name_escape_decoder_tb;

	// Escape gathering state of the predictor
	typedef enum logic [1:0] {
		ESC_NONE,
		ESC_MARK_HELD,
		ESC_DIGIT_HELD,
		ESC_UNUSED
	} esc_phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} name_byte_t;

	localparam int unsigned ITEMS_PER_PHASE = 650;
	localparam int unsigned LONG_HOLD = 120;
	localparam int unsigned DRAIN_CYCLES = 10;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic       s_tlast = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tlast;

	name_byte_t     pending_bytes[$];
	pnd_pkg::res_t  decoded_q[$];
	pnd_pkg::res_t  decoded_head;
	name_byte_t     next_byte;
	esc_phase_t     esc_phase = ESC_NONE;
	logic [7:0]     held_byte = 8'h00;
	bit             in_fired = 1'b0;
	int unsigned    tx_idle_pct = 0;
	int unsigned    rx_idle_pct = 0;
	int unsigned    rx_hold_left = 0;
	int unsigned    queued = 0;
	int unsigned    errors = 0;

	pdf_name_escape_decoder u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	// 12 ns clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// ---------------------------------------------------------------- predictor

	function automatic logic [3:0] hex_nibble(input logic [7:0] c);
		if (c >= "0" && c <= "9") return 4'(c - "0");
		if (c >= "a" && c <= "f") return 4'(c - "a" + 8'd10);
		if (c >= "A" && c <= "F") return 4'(c - "A" + 8'd10);
		return 4'd0;
	endfunction

	function automatic void queue_decoded(input logic [7:0] b, input logic last);
		pnd_pkg::res_t r;
		r.data = b;
		r.last = last;
		decoded_q.push_back(r);
	endfunction

	function automatic void decode_name_byte(input logic [7:0] b, input logic last);
		case (esc_phase)
			ESC_MARK_HELD: begin
				// name ended one byte after '#': both come out literally
				if (last) begin
					queue_decoded(pnd_pkg::ESC_MARK, 1'b0);
					queue_decoded(b, 1'b1);
					esc_phase = ESC_NONE;
				end else begin
					held_byte = b;
					esc_phase = ESC_DIGIT_HELD;
				end
			end
			ESC_DIGIT_HELD: begin
				queue_decoded(8'(hex_nibble(held_byte) * pnd_pkg::HEX_RADIX
					+ hex_nibble(b)), last);
				esc_phase = ESC_NONE;
			end
			default: begin
				// a '#' that is the last byte passes through
				if (b == pnd_pkg::ESC_MARK && !last) begin
					esc_phase = ESC_MARK_HELD;
				end else begin
					esc_phase = ESC_NONE;
					queue_decoded(b, last);
				end
			end
		endcase
	endfunction

	// ---------------------------------------------------------------- driver

	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_fired) begin
			in_fired = 1'b0;
			if (pending_bytes.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				next_byte = pending_bytes.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= next_byte.data;
				s_tlast <= next_byte.last;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Output ready, with an optional long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (rx_hold_left != 0) begin
			rx_hold_left = rx_hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// ---------------------------------------------------------------- monitor

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (decoded_q.size() == 0) begin
					$display("%0t: unexpected transfer, expected none, got byte %02h last %0b",
						$time, m_tdata, m_tlast);
					errors++;
				end else begin
					decoded_head = decoded_q.pop_front();
					if (m_tdata !== decoded_head.data) begin
						$display("%0t: out_byte mismatch, expected %02h, got %02h",
							$time, decoded_head.data, m_tdata);
						errors++;
					end
					if (m_tlast !== decoded_head.last) begin
						$display("%0t: out_last mismatch, expected %0b, got %0b",
							$time, decoded_head.last, m_tlast);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				decode_name_byte(s_tdata, s_tlast);
				in_fired = 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- stimulus

	task automatic add_byte(input logic [7:0] b, input logic last);
		name_byte_t nb;
		nb.data = b;
		nb.last = last;
		pending_bytes.push_back(nb);
		queued++;
	endtask

	function automatic logic [7:0] hex_char();
		int unsigned r;
		r = $urandom_range(21);
		if (r < 10) return 8'("0" + r);
		if (r < 16) return 8'("a" + r - 10);
		return 8'("A" + r - 16);
	endfunction

	// Mostly well-formed names with escapes; some cut short inside an escape
	task automatic gen_name();
		logic [7:0]  name_q[$];
		int unsigned len;
		int unsigned kind;
		len = $urandom_range(1, 10);
		while (name_q.size() < len) begin
			kind = $urandom_range(99);
			if (kind < 35) begin
				name_q.push_back(pnd_pkg::ESC_MARK);
				name_q.push_back(hex_char());
				name_q.push_back(hex_char());
			end else if (kind < 45) begin
				name_q.push_back(pnd_pkg::ESC_MARK);
				name_q.push_back(8'($urandom));
				name_q.push_back(8'($urandom));
			end else if (kind < 55) begin
				name_q.push_back(8'($urandom));
			end else begin
				name_q.push_back(8'($urandom_range(8'h21, 8'h7e)));
			end
		end
		kind = $urandom_range(9);
		if (kind == 0) begin
			name_q.push_back(pnd_pkg::ESC_MARK);
		end else if (kind == 1) begin
			name_q.push_back(pnd_pkg::ESC_MARK);
			name_q.push_back(hex_char());
		end
		foreach (name_q[i])
			add_byte(name_q[i], i == name_q.size() - 1);
	endtask

	// Raw bytes with frequent '#' and random last flags
	task automatic gen_noise();
		int unsigned n;
		n = $urandom_range(1, 8);
		repeat (n) begin
			if ($urandom_range(3) == 0)
				add_byte(pnd_pkg::ESC_MARK, $urandom_range(6) == 0);
			else
				add_byte(8'($urandom), $urandom_range(6) == 0);
		end
	endtask

	task automatic fill_random(input int unsigned target);
		while (queued < target) begin
			if ($urandom_range(9) == 0)
				gen_noise();
			else
				gen_name();
		end
	endtask

	// Sender stays quiet until every decoded byte has come out
	task automatic wait_drained();
		while (pending_bytes.size() != 0 || s_tvalid || decoded_q.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// phase 1: light sender gaps, heavy receiver stalls
		tx_idle_pct = 16;
		rx_idle_pct = 69;
		add_byte(8'h00, 1'b0);
		add_byte(8'hff, 1'b1);
		add_byte(pnd_pkg::ESC_MARK, 1'b1);        // name ends on '#'
		add_byte(pnd_pkg::ESC_MARK, 1'b0);        // name ends one byte after '#'
		add_byte("Z", 1'b1);
		add_byte(pnd_pkg::ESC_MARK, 1'b0);        // escape completes on the last byte
		add_byte("4", 1'b0);
		add_byte("1", 1'b1);
		add_byte(pnd_pkg::ESC_MARK, 1'b0);
		add_byte("f", 1'b0);
		add_byte("F", 1'b0);
		add_byte(pnd_pkg::ESC_MARK, 1'b0);
		add_byte("a", 1'b0);
		add_byte("9", 1'b0);
		add_byte(pnd_pkg::ESC_MARK, 1'b0);        // non-hex digits count as zero
		add_byte("g", 1'b0);
		add_byte("/", 1'b0);
		add_byte(pnd_pkg::ESC_MARK, 1'b0);
		add_byte(":", 1'b0);
		add_byte("@", 1'b0);
		add_byte(pnd_pkg::ESC_MARK, 1'b0);        // '#' used as a digit
		add_byte(pnd_pkg::ESC_MARK, 1'b0);
		add_byte(pnd_pkg::ESC_MARK, 1'b0);
		add_byte(8'hff, 1'b1);
		fill_random(ITEMS_PER_PHASE);
		wait_drained();

		// phase 2: roles swapped
		tx_idle_pct = 69;
		rx_idle_pct = 16;
		fill_random(2 * ITEMS_PER_PHASE);
		wait_drained();

		// phase 3: no idling, starting with a long receiver hold-off
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		rx_hold_left = LONG_HOLD;
		fill_random(3 * ITEMS_PER_PHASE);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && decoded_q.size() == 0) begin
			$display("** pdf_name_escape_decoder: PASSED **");
		end else begin
			$display("** pdf_name_escape_decoder: FAILED **");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#3_600_000;
		$display("** pdf_name_escape_decoder: FAILED **");
		$finish;
	end

endmodule

>>> files.f
rtl/pnd_pkg.sv
rtl/pnd_outq.sv
rtl/pdf_name_escape_decoder.sv
sim/pdf_name_escape_decoder_tb.sv
